/* rtl/anbs_pkg.sv */
// shared types and constants of the annex b nal unit splitter
`default_nettype none

package anbs_pkg;

   localparam logic [7:0] BYTE_ZERO       = 8'h00;
   localparam logic [7:0] START_BYTE      = 8'h01;
   localparam int         MIN_START_ZEROS = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_HELD,
      ST_ZEROS,
      ST_FINAL
   } state_type;

   // class of the captured byte
   typedef enum logic [1:0] {
      CLS_HUNT,
      CLS_ZERO,
      CLS_START,
      CLS_PAYLOAD
   } cls_type;

   // source of an emitted byte
   typedef enum logic [1:0] {
      SRC_HELD,
      SRC_ZERO,
      SRC_NEW
   } src_type;

   typedef struct packed {
      logic    capture;
      logic    emit;
      src_type src;
      logic    last;
      logic    hunt_upd;
      logic    zero_inc;
      logic    zero_dec;
      logic    start_end;
      logic    store_new;
      logic    clear_all;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    eos;
      logic    held_valid;
      logic    zr_is_zero;
      logic    zr_is_one;
      logic    out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/anbs_dp.sv */
// datapath: parser state, captured beat and output register
`default_nettype none

module anbs_dp #(
   parameter int MAX_ZERO_RUN = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [7:0]           req_in_byte,
   input  wire                  req_end_of_stream,
   input  anbs_pkg::cmd_type    cmd,
   output anbs_pkg::status_type status,
   input  wire                  rsp_stall,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_unit_byte,
   output logic                 rsp_unit_first,
   output logic                 rsp_unit_last
);

   localparam int ZR_W = $clog2(MAX_ZERO_RUN + 1);
   localparam logic [ZR_W-1:0] ZR_MAX = ZR_W'(MAX_ZERO_RUN);
   localparam logic [ZR_W-1:0] ZR_MIN_START = ZR_W'(anbs_pkg::MIN_START_ZEROS);
   localparam logic [ZR_W-1:0] ZR_ONE = ZR_W'(1);

   logic            synced_ff, synced_in;
   logic [ZR_W-1:0] zr_ff, zr_in;
   logic            held_valid_ff, held_valid_in;
   logic [7:0]      held_value_ff, held_value_in;
   logic            first_ff, first_in;
   logic [7:0]      b_ff, b_in;
   logic            eos_ff, eos_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            out_first_ff, out_first_in;
   logic            out_last_ff, out_last_in;
   logic [7:0]      emit_byte;

   always_comb begin
      status.eos        = eos_ff;
      status.held_valid = held_valid_ff;
      status.zr_is_zero = (zr_ff == '0);
      status.zr_is_one  = (zr_ff == ZR_ONE);
      status.out_free   = !out_valid_ff || !rsp_stall;
      if (!synced_ff) begin
         status.cls = anbs_pkg::CLS_HUNT;
      end else if (b_ff == anbs_pkg::BYTE_ZERO) begin
         status.cls = anbs_pkg::CLS_ZERO;
      end else if (b_ff == anbs_pkg::START_BYTE && zr_ff >= ZR_MIN_START) begin
         status.cls = anbs_pkg::CLS_START;
      end else begin
         status.cls = anbs_pkg::CLS_PAYLOAD;
      end
   end

   always_comb begin
      case (cmd.src)
         anbs_pkg::SRC_HELD: emit_byte = held_value_ff;
         anbs_pkg::SRC_NEW:  emit_byte = b_ff;
         default:            emit_byte = anbs_pkg::BYTE_ZERO;
      endcase
   end

   always_comb begin
      synced_in     = synced_ff;
      zr_in         = zr_ff;
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      first_in      = first_ff;
      b_in          = b_ff;
      eos_in        = eos_ff;
      out_byte_in   = out_byte_ff;
      out_first_in  = out_first_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (cmd.capture) begin
         b_in   = req_in_byte;
         eos_in = req_end_of_stream;
      end
      if (cmd.hunt_upd && b_ff == anbs_pkg::START_BYTE) begin
         synced_in     = 1'b1;
         zr_in         = '0;
         held_valid_in = 1'b0;
         first_in      = 1'b1;
      end
      if (cmd.zero_inc && zr_ff != ZR_MAX) begin
         zr_in = zr_ff + ZR_ONE;
      end
      if (cmd.zero_dec) begin
         zr_in = zr_ff - ZR_ONE;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_first_in = first_ff;
         out_last_in  = cmd.last;
         first_in     = 1'b0;
      end
      if (cmd.start_end) begin
         held_valid_in = 1'b0;
         first_in      = 1'b1;
         zr_in         = '0;
      end
      if (cmd.store_new) begin
         held_value_in = b_ff;
         held_valid_in = 1'b1;
      end
      if (cmd.clear_all) begin
         synced_in     = 1'b0;
         zr_in         = '0;
         held_valid_in = 1'b0;
         first_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff     <= 1'b0;
         zr_ff         <= '0;
         held_valid_ff <= 1'b0;
         first_ff      <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         synced_ff     <= synced_in;
         zr_ff         <= zr_in;
         held_valid_ff <= held_valid_in;
         first_ff      <= first_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_value_ff <= held_value_in;
      b_ff          <= b_in;
      eos_ff        <= eos_in;
      out_byte_ff   <= out_byte_in;
      out_first_ff  <= out_first_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_unit_byte  = out_byte_ff;
   assign rsp_unit_first = out_first_ff;
   assign rsp_unit_last  = out_last_ff;

endmodule

`default_nettype wire

/* rtl/anbs_ctrl.sv */
// controller: sequences capture, held byte, zero run and final byte
`default_nettype none

module anbs_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  anbs_pkg::status_type status,
   output anbs_pkg::cmd_type    cmd
);

   anbs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= anbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         anbs_pkg::ST_IDLE: begin
            if (req_valid) state_in = anbs_pkg::ST_EVAL;
         end
         anbs_pkg::ST_EVAL: begin
            case (status.cls)
               anbs_pkg::CLS_ZERO: begin
                  if (status.eos && status.held_valid) state_in = anbs_pkg::ST_HELD;
                  else                                 state_in = anbs_pkg::ST_IDLE;
               end
               anbs_pkg::CLS_START: begin
                  if (status.held_valid) state_in = anbs_pkg::ST_HELD;
                  else                   state_in = anbs_pkg::ST_IDLE;
               end
               anbs_pkg::CLS_PAYLOAD: begin
                  if (status.held_valid)      state_in = anbs_pkg::ST_HELD;
                  else if (!status.zr_is_zero) state_in = anbs_pkg::ST_ZEROS;
                  else                         state_in = anbs_pkg::ST_FINAL;
               end
               default: state_in = anbs_pkg::ST_IDLE;
            endcase
         end
         anbs_pkg::ST_HELD: begin
            if (status.out_free) begin
               if (status.cls != anbs_pkg::CLS_PAYLOAD) state_in = anbs_pkg::ST_IDLE;
               else if (!status.zr_is_zero)            state_in = anbs_pkg::ST_ZEROS;
               else                                    state_in = anbs_pkg::ST_FINAL;
            end
         end
         anbs_pkg::ST_ZEROS: begin
            if (status.out_free && status.zr_is_one) state_in = anbs_pkg::ST_FINAL;
         end
         anbs_pkg::ST_FINAL: begin
            if (!status.eos || status.out_free) state_in = anbs_pkg::ST_IDLE;
         end
         default: state_in = anbs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.src   = anbs_pkg::SRC_ZERO;
      req_stall = 1'b1;
      case (state_ff)
         anbs_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         anbs_pkg::ST_EVAL: begin
            case (status.cls)
               anbs_pkg::CLS_HUNT: begin
                  cmd.hunt_upd  = 1'b1;
                  cmd.clear_all = status.eos;
               end
               anbs_pkg::CLS_ZERO: begin
                  cmd.zero_inc  = 1'b1;
                  cmd.clear_all = status.eos && !status.held_valid;
               end
               anbs_pkg::CLS_START: begin
                  if (!status.held_valid) begin
                     cmd.start_end = 1'b1;
                     cmd.clear_all = status.eos;
                  end
               end
               default: ;
            endcase
         end
         anbs_pkg::ST_HELD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = anbs_pkg::SRC_HELD;
               cmd.last = (status.cls != anbs_pkg::CLS_PAYLOAD);
               if (status.cls == anbs_pkg::CLS_START) begin
                  cmd.start_end = 1'b1;
                  cmd.clear_all = status.eos;
               end else if (status.cls == anbs_pkg::CLS_ZERO) begin
                  cmd.clear_all = 1'b1;
               end
            end
         end
         anbs_pkg::ST_ZEROS: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.src      = anbs_pkg::SRC_ZERO;
               cmd.zero_dec = 1'b1;
            end
         end
         anbs_pkg::ST_FINAL: begin
            if (!status.eos) begin
               cmd.store_new = 1'b1;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.src       = anbs_pkg::SRC_NEW;
               cmd.last      = 1'b1;
               cmd.clear_all = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/annexb_nal_unit_splitter.sv */
// top level of the annex b byte stream nal unit splitter
// usage:
//  - req channel carries one stream byte per beat with an end of stream flag;
//    a beat is taken when req_valid is high and req_stall is low
//  - rsp channel carries one nal unit byte per beat with first and last marks
//  - bytes before the first 0x01 byte are skipped; trailing zeros of
//    a unit (and the leading zero of a four byte start code) are dropped
//  - the latest nonzero byte is held back until the next byte shows whether
//    it ends its unit, so results lag the input by one payload byte
// sequencing:
//  - the controller walks one input beat at a time: capture, evaluate, emit
//    the held byte and released zeros, then emit or hold the new byte
//  - the zero run saturates at MAX_ZERO_RUN, further zeros are dropped
// reset: synchronous, returns to hunting for the first start code
// stall: rsp is one output register; a stalled beat holds and the
//  controller waits in its emit state until the register frees
`default_nettype none

module annexb_nal_unit_splitter #(
   parameter int MAX_ZERO_RUN = 32
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_in_byte,
   input  wire        req_end_of_stream,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_unit_byte,
   output logic       rsp_unit_first,
   output logic       rsp_unit_last
);

   // command and status between controller and datapath
   anbs_pkg::cmd_type    cmd;
   anbs_pkg::status_type status;

   // sequencer for one input beat at a time
   anbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // parser state, captured beat, output register
   anbs_dp #(
      .MAX_ZERO_RUN (MAX_ZERO_RUN)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .cmd               (cmd),
      .status            (status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_unit_byte     (rsp_unit_byte),
      .rsp_unit_first    (rsp_unit_first),
      .rsp_unit_last     (rsp_unit_last)
   );

   // one beat in flight: after a take, the input side is closed next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a beat is still being worked");

   // the controller only loads the output register when it can take a beat
   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("output register overwritten");

   // a unit never ends on a zero byte, trailing zeros are dropped
   a_no_zero_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unit_last) |-> (rsp_unit_byte != anbs_pkg::BYTE_ZERO))
      else $error("unit ends on a zero byte");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench of the annex b nal unit splitter with its own unit predictor
`timescale 1ns / 100ps
`default_nettype none

module testbench;

   // zero run bound of the block under test, also used by the predictor
   localparam int ZERO_CAP    = 32;
   // random part length in beats, on top of the directed rows
   localparam int RAND_ITEMS  = 344;
   // generous bound: every beat at its most results, each result stalled
   localparam int CYCLE_LIMIT = 600000;
   // quiet cycles after the last expected beat
   localparam int DRAIN_WAIT  = 80;
   localparam int REPORT_MAX  = 10;

   // one unit beat as it leaves the block
   typedef struct packed {
      logic [7:0] value;
      logic       first;
      logic       last;
   } unit_beat_type;

   // directed row: stream byte, eos flag and an optional typed-in result
   // typed_n < 0 means the predictor decides, 0 or 1 is the typed count
   typedef struct {
      logic [7:0]    value;
      logic          eos;
      int            typed_n;
      unit_beat_type typed;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_stream = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_unit_byte;
   logic       rsp_unit_first;
   logic       rsp_unit_last;

   // expected unit beats, oldest first
   unit_beat_type unit_q[$];

   // predictor state
   logic       sync_seen;
   logic [5:0] zeros_pending;
   logic       hold_ok;
   logic [7:0] hold_byte;
   logic       hold_first;

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;
   int  rand_items = 0;

   annexb_nal_unit_splitter #(
      .MAX_ZERO_RUN (ZERO_CAP)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_unit_byte     (rsp_unit_byte),
      .rsp_unit_first    (rsp_unit_first),
      .rsp_unit_last     (rsp_unit_last)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog: a hung block ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver back pressure, switched off during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 16);
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   task automatic clear_predictor();
      sync_seen     = 1'b0;
      zeros_pending = '0;
      hold_ok       = 1'b0;
      hold_byte     = 8'h00;
      hold_first    = 1'b1;
   endtask

   task automatic emit_unit_byte(input logic [7:0] value, input logic last);
      unit_beat_type ub;
      ub.value   = value;
      ub.first   = hold_first;
      ub.last    = last;
      hold_first = 1'b0;
      unit_q     = {unit_q, ub};
   endtask

   // advance the splitter state by one stream byte, queue what it releases
   task automatic predict_units(input logic [7:0] value, input logic eos);
      if (!sync_seen) begin
         // hunting: only a 0x01 gets us in sync
         if (value == anbs_pkg::START_BYTE) begin
            sync_seen     = 1'b1;
            zeros_pending = '0;
            hold_ok       = 1'b0;
            hold_first    = 1'b1;
         end
         if (eos)
            clear_predictor();
      end else if (value == anbs_pkg::BYTE_ZERO) begin
         // zero run saturates, excess zeros vanish
         if (zeros_pending < ZERO_CAP)
            zeros_pending = zeros_pending + 6'd1;
         if (eos) begin
            if (hold_ok)
               emit_unit_byte(hold_byte, 1'b1);
            clear_predictor();
         end
      end else if (value == anbs_pkg::START_BYTE &&
                   zeros_pending >= anbs_pkg::MIN_START_ZEROS) begin
         // start code closes the unit, pending zeros are trailing and dropped
         if (hold_ok)
            emit_unit_byte(hold_byte, 1'b1);
         hold_ok       = 1'b0;
         hold_first    = 1'b1;
         zeros_pending = '0;
         if (eos)
            clear_predictor();
      end else begin
         // payload byte releases the held byte and the zeros behind it
         if (hold_ok)
            emit_unit_byte(hold_byte, 1'b0);
         while (zeros_pending > 0) begin
            emit_unit_byte(anbs_pkg::BYTE_ZERO, 1'b0);
            zeros_pending = zeros_pending - 6'd1;
         end
         if (eos) begin
            emit_unit_byte(value, 1'b1);
            clear_predictor();
         end else begin
            hold_byte = value;
            hold_ok   = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------

   // present one stream byte and return at the edge that takes it
   task automatic send_beat(input logic [7:0] value, input logic eos);
      if (!calm) begin
         while ($urandom_range(0, 99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_in_byte       <= value;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // random part: send, predict and count beats
   task automatic feed_random(input logic [7:0] value, input logic eos);
      send_beat(value, eos);
      rand_items++;
      predict_units(value, eos);
      // long stretch with no idling on either side
      calm = (rand_items >= 150) && (rand_items < 230);
   endtask

   // payload content: mostly random, with zeros and 0x01 often enough to
   // form short zero runs and stray start codes
   function automatic logic [7:0] pick_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12)
         return anbs_pkg::BYTE_ZERO;
      if (r < 20)
         return anbs_pkg::START_BYTE;
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------
   // response checker
   // ---------------------------------------------------------------

   task automatic note_mismatch(input string what, input unit_beat_type want,
                                input unit_beat_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s: expected byte %02h first %b last %b, %s %02h first %b last %b",
                  $realtime, what, want.value, want.first, want.last,
                  "got byte", got.value, got.first, got.last);
   endtask

   always @(posedge clock) begin
      unit_beat_type got;
      unit_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.value = rsp_unit_byte;
         got.first = rsp_unit_first;
         got.last  = rsp_unit_last;
         if (unit_q.size() == 0) begin
            want = '0;
            note_mismatch("unexpected unit beat", want, got);
         end else begin
            want = unit_q.pop_front();
            if (got.value !== want.value || got.first !== want.first ||
                got.last !== want.last)
               note_mismatch("unit beat", want, got);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // directed rows: hunting, short zero run, extra zero before a start code,
   // empty unit, end of stream on zero / payload / hunting / idle sync
   stim_row_type directed [26] = '{
      '{8'hFF, 1'b0,  0, '0},                  // hunting, skipped
      '{8'h00, 1'b0,  0, '0},                  // hunting, skipped
      '{8'h01, 1'b0,  0, '0},                  // first start code
      '{8'h00, 1'b0,  0, '0},
      '{8'h01, 1'b0, -1, '0},                  // 0x01 after one zero is payload
      '{8'hFF, 1'b0, -1, '0},
      '{8'h00, 1'b0,  0, '0},                  // four byte start code
      '{8'h00, 1'b0,  0, '0},
      '{8'h00, 1'b0,  0, '0},
      '{8'h01, 1'b0,  1, '{8'hFF, 1'b0, 1'b1}},
      '{8'h00, 1'b0,  0, '0},                  // empty unit
      '{8'h00, 1'b0,  0, '0},
      '{8'h01, 1'b0,  0, '0},
      '{8'h80, 1'b0,  0, '0},
      '{8'h7F, 1'b0, -1, '0},
      '{8'h00, 1'b1, -1, '0},                  // eos on a zero flushes held byte
      '{8'h01, 1'b0,  0, '0},
      '{8'h42, 1'b1,  1, '{8'h42, 1'b1, 1'b1}}, // one byte unit
      '{8'h01, 1'b0,  0, '0},
      '{8'hAA, 1'b0,  0, '0},
      '{8'h00, 1'b0,  0, '0},
      '{8'h55, 1'b0, -1, '0},                  // releases held byte and a zero
      '{8'h01, 1'b1, -1, '0},                  // eos on payload byte 0x01
      '{8'h00, 1'b1,  0, '0},                  // eos while hunting
      '{8'h01, 1'b0,  0, '0},
      '{8'h00, 1'b1,  0, '0}                   // eos with nothing held
   };

   initial begin
      logic [7:0] stream_q[$];
      int         n0;
      int         n_units;
      int         len;
      bit         with_eos;

      clear_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed[i]) begin
         send_beat(directed[i].value, directed[i].eos);
         n0 = unit_q.size();
         predict_units(directed[i].value, directed[i].eos);
         if (directed[i].typed_n >= 0) begin
            while (unit_q.size() > n0)
               unit_q.delete(unit_q.size() - 1);
            if (directed[i].typed_n == 1)
               unit_q = {unit_q, directed[i].typed};
         end
      end

      // random part: mostly well-formed streams, some raw noise
      while (rand_items < RAND_ITEMS) begin
         if ($urandom_range(0, 99) < 80) begin
            stream_q.delete();
            // junk ahead of the first start code
            repeat ($urandom_range(0, 3))
               stream_q = {stream_q, 8'($urandom_range(0, 255))};
            repeat ($urandom_range(2, 3))
               stream_q = {stream_q, anbs_pkg::BYTE_ZERO};
            stream_q = {stream_q, anbs_pkg::START_BYTE};
            n_units = $urandom_range(1, 4);
            for (int u = 0; u < n_units; u++) begin
               len = $urandom_range(0, 8);
               for (int k = 0; k < len; k++)
                  stream_q = {stream_q, pick_payload()};
               // now and then a long zero run, at times long enough to saturate the count
               if ($urandom_range(0, 9) == 0) begin
                  repeat ($urandom_range(28, 40))
                     stream_q = {stream_q, anbs_pkg::BYTE_ZERO};
                  stream_q = {stream_q, 8'($urandom_range(2, 255))};
               end
               if (u < n_units - 1) begin
                  repeat ($urandom_range(2, 4))
                     stream_q = {stream_q, anbs_pkg::BYTE_ZERO};
                  stream_q = {stream_q, anbs_pkg::START_BYTE};
               end else begin
                  repeat ($urandom_range(0, 2))
                     stream_q = {stream_q, anbs_pkg::BYTE_ZERO};
               end
            end
            with_eos = $urandom_range(0, 99) < 85;
            foreach (stream_q[k])
               feed_random(stream_q[k], with_eos && (k == stream_q.size() - 1));
         end else begin
            repeat ($urandom_range(4, 12))
               feed_random(pick_payload(), $urandom_range(0, 99) < 5);
         end
      end

      req_valid <= 1'b0;
      calm = 1'b0;

      // drain: wait for every expected beat, then for stray ones
      while (unit_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT)
         @(posedge clock);

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
